FILE: sv/icer_pkg.sv
`default_nettype none
package icer_pkg;

    localparam int KERNEL_MAX_DEF = 7;
    localparam int LINE_MAX_DEF   = 1024;
    localparam int PIXEL_BITS_DEF = 16;

    localparam int ACT_W      = 2;
    localparam int PIX_W      = 16;
    localparam int CIDX_W     = 6;
    localparam int COEF_W     = 16;
    localparam int OX_W       = 10;
    localparam int OY_W       = 12;
    localparam int ROW_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int WREG_W     = 11;
    localparam int HREG_W     = 13;
    localparam int KREG_W     = 3;
    localparam int HEIGHT_MAX = 4096;

    localparam logic [WREG_W-1:0] WIDTH_RST  = 11'd64;
    localparam logic [HREG_W-1:0] HEIGHT_RST = 13'd64;
    localparam logic [KREG_W-1:0] KERNEL_RST = 3'd3;

    localparam logic [ACT_W-1:0] ACT_PIXEL = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DRAIN = 2'd1;
    localparam logic [ACT_W-1:0] ACT_COEF  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_FLUSH,
        S_DIV,
        S_PUT
    } t_state;

    typedef struct packed {
        logic done;
        logic zero;
    } t_div_stat;

endpackage
`default_nettype wire

FILE: sv/icer_line_mem.sv
`default_nettype none
module icer_line_mem #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13,
    parameter int DW    = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: sv/icer_coef_mem.sv
`default_nettype none
module icer_coef_mem #(
    parameter int TAPS = 49,
    parameter int AW   = 6
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_we,
    input  wire logic [AW-1:0]                    i_waddr,
    input  wire logic signed [icer_pkg::COEF_W-1:0] i_wdata,
    input  wire logic [AW-1:0]                    i_raddr,
    output logic signed [icer_pkg::COEF_W-1:0]      o_rdata
);

    logic signed [icer_pkg::COEF_W-1:0] r_mem [TAPS];
    logic signed [icer_pkg::COEF_W-1:0] r_rd;
    logic [TAPS-1:0]                    r_vld;
    logic                               r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd <= r_mem[i_raddr];
    end

    // unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_rvld <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_rvld ? r_rd : '0;

endmodule
`default_nettype wire

FILE: sv/icer_div.sv
`default_nettype none
module icer_div #(
    parameter int NW = 39,
    parameter int DW = 22,
    parameter int PB = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic signed [NW-1:0] i_num,
    input  wire logic signed [DW-1:0] i_den,
    output icer_pkg::t_div_stat       o_stat,
    output logic [PB-1:0]             o_quot
);

    localparam int CNW = $clog2(NW + 1);

    logic           r_busy;
    logic           r_done;
    logic [CNW-1:0] r_cnt;
    logic [NW-1:0]  r_q;
    logic [DW-1:0]  r_rem;
    logic [DW-1:0]  r_b;
    logic           r_kill;
    logic           r_zero;

    logic [NW-1:0]  w_anum;
    logic [DW-1:0]  w_aden;
    logic [DW:0]    w_sh;
    logic [DW:0]    w_diff;
    logic           w_ge;
    logic           w_sat;

    assign w_anum = i_num[NW-1] ? (~i_num + 1'b1) : i_num;
    assign w_aden = i_den[DW-1] ? (~i_den + 1'b1) : i_den;
    assign w_sh   = {r_rem, r_q[NW-1]};
    assign w_diff = w_sh - {1'b0, r_b};
    assign w_ge   = (w_sh >= {1'b0, r_b});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // restoring division on magnitudes, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q    <= w_anum;
            r_b    <= w_aden;
            r_rem  <= '0;
            r_zero <= (i_den == '0);
            r_kill <= (i_den == '0) || (i_num == '0) || (i_num[NW-1] != i_den[DW-1]);
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DW-1:0] : w_sh[DW-1:0];
            r_q   <= {r_q[NW-2:0], w_ge};
        end
    end

    assign w_sat       = |r_q[NW-1:PB];
    assign o_quot      = r_kill ? '0 : (w_sat ? '1 : r_q[PB-1:0]);
    assign o_stat.done = r_done;
    assign o_stat.zero = r_zero;

endmodule
`default_nettype wire

FILE: sv/image_convolution_edge_renorm_core.sv
// Channel  Handshake                  Payload
// in       i_in_valid / o_in_ready    action, pixel, coef_index, coef_value
// out      o_out_valid / i_out_ready  out_pixel, out_x, out_y, zero_divisor, last_of_frame
// cfg      i_cfg_we                   i_cfg_idx, i_cfg_data
//
// Coefficient loads and stream steps that yield no pixel leave the core idle and ready.
// A step that yields a pixel walks the k*k taps, one tap a cycle through the
// single line-store read port, then runs a bit-serial divider over the NW-bit
// numerator; the input is not ready again until the result is in the output register.
// Reset is synchronous; line-store contents stay undefined, coefficients read as 0.
// A stalled output holds its beat while the next input item is taken.
`default_nettype none
module image_convolution_edge_renorm_core #(
    parameter int KERNEL_MAX = icer_pkg::KERNEL_MAX_DEF,
    parameter int LINE_MAX   = icer_pkg::LINE_MAX_DEF,
    parameter int PIXEL_BITS = icer_pkg::PIXEL_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic [icer_pkg::ACT_W-1:0]            i_action,
    input  wire logic [icer_pkg::PIX_W-1:0]            i_pixel,
    input  wire logic [icer_pkg::CIDX_W-1:0]           i_coef_index,
    input  wire logic signed [icer_pkg::COEF_W-1:0]    i_coef_value,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic [icer_pkg::PIX_W-1:0]                 o_out_pixel,
    output logic [icer_pkg::OX_W-1:0]                  o_out_x,
    output logic [icer_pkg::OY_W-1:0]                  o_out_y,
    output logic                                       o_zero_divisor,
    output logic                                       o_last_of_frame,
    input  wire logic                                  i_cfg_we,
    input  wire logic [icer_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [icer_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int RK   = KERNEL_MAX + 1;
    localparam int TAPS = KERNEL_MAX * KERNEL_MAX;
    localparam int CW   = $clog2(LINE_MAX);
    localparam int WW   = CW + 1;
    localparam int SW   = $clog2(RK);
    localparam int LAW  = $clog2(RK * LINE_MAX);
    localparam int KW   = $clog2(KERNEL_MAX + 1);
    localparam int CAW  = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int PW   = $clog2(KERNEL_MAX * LINE_MAX + KERNEL_MAX + 1);
    localparam int PRW  = PIXEL_BITS + icer_pkg::COEF_W + 1;
    localparam int NW   = PRW + $clog2(TAPS + 1);
    localparam int DW   = icer_pkg::COEF_W + $clog2(TAPS + 1);
    localparam int RW   = icer_pkg::ROW_W;
    localparam int YW   = RW + 2;
    localparam int XW   = CW + 2;
    localparam int SSW  = SW + KW + 2;

    // configuration
    logic [icer_pkg::WREG_W-1:0] r_width;
    logic [icer_pkg::HREG_W-1:0] r_height;
    logic [icer_pkg::KREG_W-1:0] r_ksize;
    logic [WW-1:0]               w_w_eff;
    logic [RW-1:0]               w_h_eff;
    logic [KW-1:0]               w_k_eff;
    logic [KW-1:0]               w_r;
    logic [PW-1:0]               w_lag;

    // stream positions
    logic [CW-1:0]               r_in_col;
    logic [RW-1:0]               r_in_row;
    logic [SW-1:0]               r_in_slot;
    logic [CW-1:0]               r_out_col;
    logic [icer_pkg::OY_W-1:0]   r_out_row;
    logic [SW-1:0]               r_out_slot;
    logic [PW-1:0]               r_pre;

    // pixel under work
    logic [CW-1:0]               r_cx;
    logic [icer_pkg::OY_W-1:0]   r_cy;
    logic [SW-1:0]               r_cslot;
    logic                        r_clast;

    icer_pkg::t_state            r_state;
    icer_pkg::t_state            n_state;
    logic [KW-1:0]               r_ti;
    logic [KW-1:0]               r_tj;
    logic [1:0]                  r_fl;

    logic                        w_acc;
    logic                        w_stream;
    logic                        w_emit;
    logic                        w_last;
    logic                        w_cfg_hit;
    logic                        w_in_wr;
    logic [WW-1:0]               w_in_col_nx;
    logic [LAW-1:0]              w_waddr;
    logic [PIXEL_BITS-1:0]       w_wdata;
    logic [PIXEL_BITS+icer_pkg::PIX_W-1:0] w_in_ext;
    logic                        w_coef_we;
    logic                        w_tap_last;
    logic                        w_div_go;

    logic signed [YW-1:0]        w_ty;
    logic signed [XW-1:0]        w_tx;
    logic signed [SSW-1:0]       w_ts;
    logic [SW-1:0]               w_slot;
    logic                        w_tap_in;
    logic [LAW-1:0]              w_raddr;
    logic [CAW-1:0]              w_caddr;

    logic [PIXEL_BITS-1:0]       w_lpix;
    logic signed [icer_pkg::COEF_W-1:0] w_coef;
    logic signed [PRW-1:0]       w_prod;
    logic                        r_a_v;
    logic                        r_a_in;
    logic                        r_b_v;
    logic signed [PRW-1:0]       r_prod;
    logic signed [NW-1:0]        r_num;
    logic signed [DW-1:0]        r_den;

    icer_pkg::t_div_stat         w_div_stat;
    logic [PIXEL_BITS-1:0]       w_quot;

    logic                        r_ovld;
    logic [PIXEL_BITS-1:0]       r_opix;
    logic [CW-1:0]               r_ox;
    logic [icer_pkg::OY_W-1:0]   r_oy;
    logic                        r_ozero;
    logic                        r_olast;
    logic [PIXEL_BITS+icer_pkg::PIX_W-1:0] w_opix_ext;
    logic [CW+icer_pkg::OX_W-1:0]          w_ox_ext;

    // effective configuration
    always_comb begin
        int kk;
        kk = int'(r_ksize);
        if (kk > KERNEL_MAX) kk = KERNEL_MAX;
        if (kk == 0) kk = 1;
        if ((kk % 2) == 0) kk = kk - 1;
        w_k_eff = KW'(kk);

        if (r_width == '0) begin
            w_w_eff = WW'(1);
        end else if (int'(r_width) > LINE_MAX) begin
            w_w_eff = WW'(LINE_MAX);
        end else begin
            w_w_eff = WW'(r_width);
        end

        if (r_height == '0) begin
            w_h_eff = RW'(1);
        end else if (int'(r_height) > icer_pkg::HEIGHT_MAX) begin
            w_h_eff = RW'(icer_pkg::HEIGHT_MAX);
        end else begin
            w_h_eff = RW'(r_height);
        end
    end

    assign w_r   = w_k_eff >> 1;
    assign w_lag = PW'(w_r) * PW'(w_w_eff) + PW'(w_r);

    // input side
    assign o_in_ready  = (r_state == icer_pkg::S_IDLE);
    assign w_acc       = i_in_valid && o_in_ready;
    assign w_stream    = w_acc && (i_action == icer_pkg::ACT_PIXEL ||
                                   i_action == icer_pkg::ACT_DRAIN);
    assign w_coef_we   = w_acc && (i_action == icer_pkg::ACT_COEF) &&
                         (int'(i_coef_index) < TAPS);
    assign w_emit      = (r_pre >= w_lag);
    assign w_last      = (WW'(r_out_col) == w_w_eff - 1'b1) &&
                         (RW'(r_out_row) == w_h_eff - 1'b1);
    assign w_in_wr     = w_stream && (r_in_row < w_h_eff) && (WW'(r_in_col) < w_w_eff);
    assign w_in_col_nx = WW'(r_in_col) + 1'b1;
    assign w_cfg_hit   = (i_cfg_idx == icer_pkg::CFG_WIDTH) ||
                         (i_cfg_idx == icer_pkg::CFG_HEIGHT) ||
                         (i_cfg_idx == icer_pkg::CFG_KERNEL);
    assign w_in_ext    = {{PIXEL_BITS{1'b0}}, i_pixel};
    assign w_wdata     = (i_action == icer_pkg::ACT_PIXEL) ? w_in_ext[PIXEL_BITS-1:0] : '0;
    assign w_waddr     = LAW'(r_in_slot) * LAW'(LINE_MAX) + LAW'(r_in_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= icer_pkg::WIDTH_RST;
            r_height   <= icer_pkg::HEIGHT_RST;
            r_ksize    <= icer_pkg::KERNEL_RST;
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_in_slot  <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_out_slot <= '0;
            r_pre      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                icer_pkg::CFG_WIDTH: begin
                    r_width <= i_cfg_data[icer_pkg::WREG_W-1:0];
                end
                icer_pkg::CFG_HEIGHT: begin
                    r_height <= i_cfg_data[icer_pkg::HREG_W-1:0];
                end
                icer_pkg::CFG_KERNEL: begin
                    r_ksize <= i_cfg_data[icer_pkg::KREG_W-1:0];
                end
                default: begin
                end
            endcase
            if (w_cfg_hit) begin
                r_in_col   <= '0;
                r_in_row   <= '0;
                r_in_slot  <= '0;
                r_out_col  <= '0;
                r_out_row  <= '0;
                r_out_slot <= '0;
                r_pre      <= '0;
            end
        end else if (w_stream) begin
            if (!w_emit) begin
                r_pre <= r_pre + 1'b1;
            end
            if (w_in_col_nx >= w_w_eff) begin
                r_in_col  <= '0;
                r_in_row  <= r_in_row + 1'b1;
                r_in_slot <= (r_in_slot == SW'(RK - 1)) ? '0 : r_in_slot + 1'b1;
            end else begin
                r_in_col <= w_in_col_nx[CW-1:0];
            end
            if (w_emit) begin
                if (WW'(r_out_col) + 1'b1 >= w_w_eff) begin
                    r_out_col  <= '0;
                    r_out_row  <= r_out_row + 1'b1;
                    r_out_slot <= (r_out_slot == SW'(RK - 1)) ? '0 : r_out_slot + 1'b1;
                end else begin
                    r_out_col <= r_out_col + 1'b1;
                end
                // frame done: start over
                if (w_last) begin
                    r_in_col   <= '0;
                    r_in_row   <= '0;
                    r_in_slot  <= '0;
                    r_out_col  <= '0;
                    r_out_row  <= '0;
                    r_out_slot <= '0;
                    r_pre      <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stream && w_emit) begin
            r_cx    <= r_out_col;
            r_cy    <= r_out_row;
            r_cslot <= r_out_slot;
            r_clast <= w_last;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= icer_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign w_tap_last = (r_ti == w_k_eff - 1'b1) && (r_tj == w_k_eff - 1'b1);
    assign w_div_go   = (r_state == icer_pkg::S_FLUSH) && (r_fl == 2'd2);

    always_comb begin
        n_state = r_state;
        case (r_state)
            icer_pkg::S_IDLE: begin
                if (w_stream && w_emit) n_state = icer_pkg::S_RUN;
            end
            icer_pkg::S_RUN: begin
                if (w_tap_last) n_state = icer_pkg::S_FLUSH;
            end
            icer_pkg::S_FLUSH: begin
                if (w_div_go) n_state = icer_pkg::S_DIV;
            end
            icer_pkg::S_DIV: begin
                if (w_div_stat.done) n_state = icer_pkg::S_PUT;
            end
            icer_pkg::S_PUT: begin
                if (!r_ovld || i_out_ready) n_state = icer_pkg::S_IDLE;
            end
            default: begin
                n_state = icer_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ti <= '0;
            r_tj <= '0;
            r_fl <= '0;
        end else begin
            if (r_state == icer_pkg::S_IDLE) begin
                r_ti <= '0;
                r_tj <= '0;
            end else if (r_state == icer_pkg::S_RUN) begin
                if (r_tj == w_k_eff - 1'b1) begin
                    r_tj <= '0;
                    r_ti <= r_ti + 1'b1;
                end else begin
                    r_tj <= r_tj + 1'b1;
                end
            end
            r_fl <= (r_state == icer_pkg::S_FLUSH) ? r_fl + 1'b1 : '0;
        end
    end

    // tap address and frame test
    always_comb begin
        w_ty = $signed(YW'(r_cy)) + $signed(YW'(r_ti)) - $signed(YW'(w_r));
        w_tx = $signed(XW'(r_cx)) + $signed(XW'(r_tj)) - $signed(XW'(w_r));
        w_ts = $signed(SSW'(r_cslot)) + $signed(SSW'(r_ti)) - $signed(SSW'(w_r));
        if (w_ts < 0) begin
            w_ts = w_ts + SSW'(RK);
        end else if (w_ts >= $signed(SSW'(RK))) begin
            w_ts = w_ts - SSW'(RK);
        end
        w_slot   = w_ts[SW-1:0];
        w_tap_in = !w_ty[YW-1] && (w_ty < $signed(YW'(w_h_eff))) &&
                   !w_tx[XW-1] && (w_tx < $signed(XW'(w_w_eff)));
        w_raddr  = LAW'(w_slot) * LAW'(LINE_MAX) + LAW'(w_tx[CW-1:0]);
        w_caddr  = CAW'(r_ti) * CAW'(KERNEL_MAX) + CAW'(r_tj);
    end

    icer_line_mem #(
        .DEPTH (RK * LINE_MAX),
        .AW    (LAW),
        .DW    (PIXEL_BITS)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (w_in_wr),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_lpix)
    );

    icer_coef_mem #(
        .TAPS (TAPS),
        .AW   (CAW)
    ) u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_coef_we),
        .i_waddr (CAW'(i_coef_index)),
        .i_wdata (i_coef_value),
        .i_raddr (w_caddr),
        .o_rdata (w_coef)
    );

    // multiply-accumulate: read, multiply, add
    assign w_prod = $signed({1'b0, w_lpix}) * w_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else begin
            r_a_v <= (r_state == icer_pkg::S_RUN);
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_in <= w_tap_in;
        if (w_stream && w_emit) begin
            r_num <= '0;
            r_den <= '0;
        end else begin
            if (r_a_v) begin
                r_prod <= r_a_in ? w_prod : '0;
                if (r_a_in) begin
                    r_den <= r_den + DW'(w_coef);
                end
            end
            if (r_b_v) begin
                r_num <= r_num + NW'(r_prod);
            end
        end
    end

    icer_div #(
        .NW (NW),
        .DW (DW),
        .PB (PIXEL_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_go),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_stat  (w_div_stat),
        .o_quot  (w_quot)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (r_state == icer_pkg::S_PUT && (!r_ovld || i_out_ready)) begin
            r_ovld <= 1'b1;
        end else if (i_out_ready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == icer_pkg::S_PUT && (!r_ovld || i_out_ready)) begin
            r_opix  <= w_quot;
            r_ox    <= r_cx;
            r_oy    <= r_cy;
            r_ozero <= w_div_stat.zero;
            r_olast <= r_clast;
        end
    end

    assign w_opix_ext      = {{icer_pkg::PIX_W{1'b0}}, r_opix};
    assign w_ox_ext        = {{icer_pkg::OX_W{1'b0}}, r_ox};
    assign o_out_valid     = r_ovld;
    assign o_out_pixel     = w_opix_ext[icer_pkg::PIX_W-1:0];
    assign o_out_x         = w_ox_ext[icer_pkg::OX_W-1:0];
    assign o_out_y         = r_oy;
    assign o_zero_divisor  = r_ozero;
    assign o_last_of_frame = r_olast;

endmodule
`default_nettype wire

FILE: sv/icer_chk.sv
`default_nettype none
module icer_chk (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_in_valid,
    input wire logic                             o_in_ready,
    input wire logic [icer_pkg::ACT_W-1:0]       i_action,
    input wire logic                             o_out_valid,
    input wire logic                             i_out_ready,
    input wire logic [icer_pkg::PIX_W-1:0]       o_out_pixel,
    input wire logic                             o_zero_divisor
);

    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_pixel))
        else $error("stalled output beat changed");

    a_zero_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_divisor |-> o_out_pixel == '0)
        else $error("zero divisor with nonzero pixel");

    a_coef_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_action == icer_pkg::ACT_COEF && !o_out_valid
        |=> !o_out_valid)
        else $error("coefficient load produced a beat");

endmodule

bind image_convolution_edge_renorm_core icer_chk u_icer_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_action       (i_action),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_out_pixel    (o_out_pixel),
    .o_zero_divisor (o_zero_divisor)
);
`default_nettype wire
